// ----- hw/rtl/rsa_pkg.sv -----
package rsa_pkg;

    localparam int SLOTS_DEF = 5;
    localparam int MAX_SLOTS = 8;

    localparam int IDX_W = 3;
    localparam int TAG_W = 16;
    localparam int CNT_W = 8;
    localparam int ST_W  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_FREE  = 2'd2;
    localparam logic [ST_W-1:0] ST_MISMATCH = 2'd3;

    // stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic             req_type;
        logic [TAG_W-1:0] wave_tag;
        logic [IDX_W-1:0] slot_index;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic             needs_load;
        logic [ST_W-1:0]  status;
    } t_res;

    // one slot write per item
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             wr_tag;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] count;
    } t_upd;

endpackage

// ----- hw/rtl/rsa_slot_table.sv -----
module rsa_slot_table #(
    parameter int SLOTS = rsa_pkg::SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_commit,
    input  rsa_pkg::t_upd           i_upd,
    output logic [rsa_pkg::TAG_W-1:0] o_tags   [SLOTS],
    output logic [rsa_pkg::CNT_W-1:0] o_counts [SLOTS]
);

    logic [rsa_pkg::TAG_W-1:0] r_tags   [SLOTS];
    logic [rsa_pkg::CNT_W-1:0] r_counts [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_tags[i]   <= '0;
                r_counts[i] <= '0;
            end
        end else if (i_commit && i_upd.en) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (i_upd.idx == rsa_pkg::IDX_W'(i)) begin
                    if (i_upd.wr_tag) begin
                        r_tags[i] <= i_upd.tag;
                    end
                    r_counts[i] <= i_upd.count;
                end
            end
        end
    end

    assign o_tags   = r_tags;
    assign o_counts = r_counts;

endmodule

// ----- hw/rtl/rsa_decide.sv -----
module rsa_decide #(
    parameter int SLOTS = rsa_pkg::SLOTS_DEF
) (
    input  rsa_pkg::t_req             i_req,
    input  logic [rsa_pkg::TAG_W-1:0] i_tags   [SLOTS],
    input  logic [rsa_pkg::CNT_W-1:0] i_counts [SLOTS],
    output rsa_pkg::t_res             o_res,
    output rsa_pkg::t_upd             o_upd
);

    always_comb begin
        logic                      hit;
        logic [rsa_pkg::IDX_W-1:0] hit_idx;
        logic                      nu_hit;
        logic [rsa_pkg::IDX_W-1:0] nu_idx;
        logic                      idle_hit;
        logic [rsa_pkg::IDX_W-1:0] idle_idx;
        logic                      rel_ok_idx;
        logic [rsa_pkg::TAG_W-1:0] rel_tag;
        logic [rsa_pkg::CNT_W-1:0] rel_cnt;
        logic [rsa_pkg::CNT_W-1:0] hit_cnt;

        hit        = 1'b0;
        hit_idx    = '0;
        hit_cnt    = '0;
        nu_hit     = 1'b0;
        nu_idx     = '0;
        idle_hit   = 1'b0;
        idle_idx   = '0;
        rel_ok_idx = 1'b0;
        rel_tag    = '0;
        rel_cnt    = '0;

        // first tag match; highest never-used and highest idle slot
        for (int i = 0; i < SLOTS; i++) begin
            if (!hit && i_tags[i] == i_req.wave_tag) begin
                hit     = 1'b1;
                hit_idx = rsa_pkg::IDX_W'(i);
                hit_cnt = i_counts[i];
            end
            if (i_tags[i] == '0) begin
                nu_hit = 1'b1;
                nu_idx = rsa_pkg::IDX_W'(i);
            end
            if (i_counts[i] == '0) begin
                idle_hit = 1'b1;
                idle_idx = rsa_pkg::IDX_W'(i);
            end
            if (i_req.slot_index == rsa_pkg::IDX_W'(i)) begin
                rel_ok_idx = 1'b1;
                rel_tag    = i_tags[i];
                rel_cnt    = i_counts[i];
            end
        end

        o_res = '{slot: '0, needs_load: 1'b0, status: rsa_pkg::ST_OK};
        o_upd = '{en: 1'b0, idx: '0, wr_tag: 1'b0, tag: i_req.wave_tag, count: '0};

        if (i_req.req_type == rsa_pkg::REQ_ACQUIRE) begin
            if (i_req.wave_tag == '0) begin
                o_res.status = rsa_pkg::ST_INVALID;
            end else if (hit) begin
                o_res.slot  = hit_idx;
                o_upd.en    = 1'b1;
                o_upd.idx   = hit_idx;
                o_upd.count = (hit_cnt == rsa_pkg::CNT_MAX) ? hit_cnt
                                                            : hit_cnt + rsa_pkg::CNT_W'(1);
            end else if (nu_hit || idle_hit) begin
                o_res.slot       = nu_hit ? nu_idx : idle_idx;
                o_res.needs_load = 1'b1;
                o_upd.en         = 1'b1;
                o_upd.idx        = nu_hit ? nu_idx : idle_idx;
                o_upd.wr_tag     = 1'b1;
                o_upd.count      = rsa_pkg::CNT_W'(1);
            end else begin
                o_res.status = rsa_pkg::ST_NO_FREE;
            end
        end else begin
            o_res.slot = i_req.slot_index;
            if (!rel_ok_idx) begin
                o_res.status = rsa_pkg::ST_INVALID;
            end else if (i_req.wave_tag != '0 && rel_tag != i_req.wave_tag) begin
                o_res.status = rsa_pkg::ST_MISMATCH;
            end else begin
                // count stops at zero
                o_upd.en    = 1'b1;
                o_upd.idx   = i_req.slot_index;
                o_upd.count = (rel_cnt == '0) ? rel_cnt : rel_cnt - rsa_pkg::CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/refcounted_slot_allocator_top.sv -----
// channel   dir  tdata fields (low bit up)                      tuser
// s (req)   in   wave_tag[15:0], slot_index[18:16], zero pad    req_type
// m (res)   out  slot[2:0], needs_load[3], status[5:4], zero pad  -
//
// one item per cycle sustained while results are taken; an accepted request goes to the request register,
// then through slot table lookup and update into the result register
// slot table state is committed as the item moves into the result register
// synchronous active-low reset empties the table (all tags and counts zero)
// a stalled result holds the pipe; the request register still fills behind it
module refcounted_slot_allocator_top #(
    parameter int SLOTS = rsa_pkg::SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [rsa_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // wave_tag, slot_index
    input  logic                               i_s_tuser,   // req_type
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [rsa_pkg::OUT_TDATA_W-1:0]    o_m_tdata    // slot, needs_load, status
);

    logic                r_in_valid;
    rsa_pkg::t_req       r_req;
    logic                r_out_valid;
    rsa_pkg::t_res       r_res;
    logic                advance;
    rsa_pkg::t_res       n_res;
    rsa_pkg::t_upd       upd;
    logic [rsa_pkg::TAG_W-1:0] tags   [SLOTS];
    logic [rsa_pkg::CNT_W-1:0] counts [SLOTS];

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_req.req_type   <= i_s_tuser;
            r_req.wave_tag   <= i_s_tdata[rsa_pkg::TAG_W-1:0];
            r_req.slot_index <= i_s_tdata[rsa_pkg::TAG_W +: rsa_pkg::IDX_W];
        end
    end

    rsa_slot_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (advance),
        .i_upd    (upd),
        .o_tags   (tags),
        .o_counts (counts)
    );

    rsa_decide #(
        .SLOTS (SLOTS)
    ) u_decide (
        .i_req    (r_req),
        .i_tags   (tags),
        .i_counts (counts),
        .o_res    (n_res),
        .o_upd    (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_res.status, r_res.needs_load, r_res.slot};

endmodule

// ----- tb/sv/refcounted_slot_allocator_top_tb.sv -----
`timescale 1ns / 1ps

module refcounted_slot_allocator_top_tb;

    localparam int N_SLOTS = rsa_pkg::SLOTS_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rsa_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rsa_pkg::OUT_TDATA_W-1:0] m_tdata;

    refcounted_slot_allocator_top #(
        .SLOTS(N_SLOTS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // slot table as the testbench sees it
    logic [rsa_pkg::TAG_W-1:0] owner_tag [N_SLOTS];
    logic [rsa_pkg::CNT_W-1:0] use_count [N_SLOTS];

    rsa_pkg::t_req req_q[$];
    rsa_pkg::t_res grant_q[$];
    rsa_pkg::t_req cur_req;
    int   n_queued = 0;
    int   n_checked = 0;
    int   n_errors = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   rx_cyc = 0;
    int   rx_mode = 0;

    function automatic rsa_pkg::t_res predict_grant(rsa_pkg::t_req rq);
        rsa_pkg::t_res r;
        int   hit;
        int   fresh;
        int   idle;
        r.slot = '0;
        r.needs_load = 1'b0;
        r.status = rsa_pkg::ST_OK;
        if (rq.req_type == rsa_pkg::REQ_ACQUIRE) begin
            hit = -1;
            fresh = -1;
            idle = -1;
            if (rq.wave_tag == '0) begin
                r.status = rsa_pkg::ST_INVALID;
                return r;
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                if (hit < 0 && owner_tag[i] == rq.wave_tag) hit = i;
                if (owner_tag[i] == '0) fresh = i;
                if (use_count[i] == '0) idle = i;
            end
            if (hit >= 0) begin
                if (use_count[hit] != rsa_pkg::CNT_MAX)
                    use_count[hit] = use_count[hit] + rsa_pkg::CNT_W'(1);
                r.slot = hit[rsa_pkg::IDX_W-1:0];
            end else begin
                // a never-used slot wins over an idle one
                if (fresh < 0) fresh = idle;
                if (fresh < 0) begin
                    r.status = rsa_pkg::ST_NO_FREE;
                end else begin
                    owner_tag[fresh] = rq.wave_tag;
                    use_count[fresh] = rsa_pkg::CNT_W'(1);
                    r.slot = fresh[rsa_pkg::IDX_W-1:0];
                    r.needs_load = 1'b1;
                end
            end
        end else begin
            r.slot = rq.slot_index;
            if (int'(rq.slot_index) >= N_SLOTS) begin
                r.status = rsa_pkg::ST_INVALID;
            end else if (rq.wave_tag != '0 && owner_tag[rq.slot_index] != rq.wave_tag) begin
                r.status = rsa_pkg::ST_MISMATCH;
            end else if (use_count[rq.slot_index] != '0) begin
                use_count[rq.slot_index] = use_count[rq.slot_index] - rsa_pkg::CNT_W'(1);
            end
        end
        return r;
    endfunction

    // sender: bursts with random gaps, valid held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            burst_left = $urandom_range(1, 30);
            gap_left = 0;
            for (int i = 0; i < N_SLOTS; i++) begin
                owner_tag[i] = '0;
                use_count[i] = '0;
            end
        end else begin
            if (s_tvalid && s_tready) grant_q.push_back(predict_grant(cur_req));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, cur_req.slot_index, cur_req.wave_tag};
                    s_tuser <= cur_req.req_type;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                               : $urandom_range(0, 3);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern drawn at random from four modes
    always @(posedge i_clk) begin
        rx_cyc++;
        if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cyc % 3 != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        rsa_pkg::t_res want;
        rsa_pkg::t_res got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.slot = m_tdata[2:0];
            got.needs_load = m_tdata[3];
            got.status = m_tdata[5:4];
            n_checked++;
            if (grant_q.size() == 0) begin
                if (n_errors < 10)
                    $display("unexpected result: slot %0d load %0d status %0d",
                             got.slot, got.needs_load, got.status);
                n_errors++;
            end else begin
                want = grant_q.pop_front();
                if (got != want) begin
                    if (n_errors < 10)
                        $display("result %0d: slot %0d/%0d load %0d/%0d status %0d/%0d (exp/got)",
                                 n_checked, want.slot, got.slot, want.needs_load,
                                 got.needs_load, want.status, got.status);
                    n_errors++;
                end
            end
        end
    end

    task automatic queue_req(input logic rt, input logic [rsa_pkg::TAG_W-1:0] tg,
                             input logic [rsa_pkg::IDX_W-1:0] ix);
        rsa_pkg::t_req r;
        r.req_type = rt;
        r.wave_tag = tg;
        r.slot_index = ix;
        req_q.push_back(r);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_checked < n_queued) @(posedge i_clk);
    endtask

    initial begin
        logic [rsa_pkg::TAG_W-1:0] pool [6];
        logic [rsa_pkg::TAG_W-1:0] hot_tag;
        int                        pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edge cases of acquire and release
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'h0000, 3'd5);
        queue_req(rsa_pkg::REQ_RELEASE, 16'h0000, 3'd7);
        queue_req(rsa_pkg::REQ_RELEASE, 16'hFFFF, 3'd5);
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'hFFFF, 3'd7);
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'h0001, 3'd0);
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'hFFFF, 3'd2);
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'h8000, 3'd0);
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'h5555, 3'd0);
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'hAAAA, 3'd0);
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'h1234, 3'd0);  // table full
        queue_req(rsa_pkg::REQ_RELEASE, 16'h0002, 3'd3);  // wrong owner
        queue_req(rsa_pkg::REQ_RELEASE, 16'h0001, 3'd3);
        queue_req(rsa_pkg::REQ_RELEASE, 16'h0000, 3'd3);  // count already zero
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'h1234, 3'd0);  // reuses idle slot
        queue_req(rsa_pkg::REQ_RELEASE, 16'h1234, 3'd3);
        queue_req(rsa_pkg::REQ_RELEASE, 16'h0000, 3'd4);
        queue_req(rsa_pkg::REQ_RELEASE, 16'hFFFF, 3'd4);
        queue_req(rsa_pkg::REQ_RELEASE, 16'h0000, 3'd0);
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'h00FF, 3'd0);
        queue_req(rsa_pkg::REQ_ACQUIRE, 16'h0001, 3'd0);
        queue_req(rsa_pkg::REQ_RELEASE, 16'h8000, 3'd2);
        queue_req(rsa_pkg::REQ_RELEASE, 16'h0000, 3'd6);
        wait_drained();

        // bring every count to zero, then drive one tag into count saturation
        for (int r = 0; r < 3; r++)
            for (int i = 0; i < N_SLOTS; i++)
                queue_req(rsa_pkg::REQ_RELEASE, 16'h0000, i[rsa_pkg::IDX_W-1:0]);
        hot_tag = rsa_pkg::TAG_W'($urandom_range(1, 65535));
        for (int n = 0; n < 260; n++)
            queue_req(rsa_pkg::REQ_ACQUIRE, hot_tag, 3'($urandom_range(0, 7)));
        for (int r = 0; r < 4; r++)
            for (int i = 0; i < N_SLOTS; i++)
                queue_req(rsa_pkg::REQ_RELEASE, hot_tag, i[rsa_pkg::IDX_W-1:0]);

        for (int i = 0; i < 6; i++) pool[i] = rsa_pkg::TAG_W'($urandom_range(1, 65535));
        for (int n = 0; n < 700; n++) begin
            if (n % 90 == 89)
                pool[$urandom_range(0, 5)] = rsa_pkg::TAG_W'($urandom_range(1, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 42)
                queue_req(rsa_pkg::REQ_ACQUIRE, pool[$urandom_range(0, 5)],
                          3'($urandom_range(0, 7)));
            else if (pick < 44)
                queue_req(rsa_pkg::REQ_ACQUIRE, 16'h0000, 3'($urandom_range(0, 7)));
            else if (pick < 50)
                queue_req(rsa_pkg::REQ_ACQUIRE, rsa_pkg::TAG_W'($urandom_range(0, 65535)),
                          3'($urandom_range(0, 7)));
            else if (pick < 80)
                queue_req(rsa_pkg::REQ_RELEASE,
                          $urandom_range(0, 1) ? pool[$urandom_range(0, 5)] : 16'h0000,
                          3'($urandom_range(0, N_SLOTS - 1)));
            else if (pick < 92)
                queue_req(rsa_pkg::REQ_RELEASE, 16'h0000, 3'($urandom_range(0, N_SLOTS - 1)));
            else
                queue_req(rsa_pkg::REQ_RELEASE, rsa_pkg::TAG_W'($urandom_range(0, 65535)),
                          3'($urandom_range(0, 7)));
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && grant_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
